### rtl/core/spb_pkg.sv
// Serpent block cipher package: payload structs, FSM states, S-box tables
// and the round functions. Used by serpent_block_cipher and spb_checker in rtl/core.
`default_nettype none
package spb_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int KEY_ROWS    = ROUND_COUNT + 1;
  localparam int KEY_WORDS   = 4 * KEY_ROWS;
  localparam int ROW_AW      = $clog2(KEY_ROWS);
  localparam int WORD_IW     = $clog2(KEY_WORDS);
  localparam int CFG_AW      = 6;
  localparam int CFG_DW      = 64;
  localparam logic [31:0] GOLDEN = 32'h9E3779B9;

  localparam logic [2:0] REG_KLEN = 3'd0;
  localparam logic [2:0] REG_KEY0 = 3'd1;
  localparam logic [2:0] REG_KEY1 = 3'd2;
  localparam logic [2:0] REG_KEY2 = 3'd3;
  localparam logic [2:0] REG_KEY3 = 3'd4;

  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;
  localparam logic [1:0] KLEN_RSV = 2'd3;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef logic [3:0][31:0] blk_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] in_word3;
    logic [31:0] in_word2;
    logic [31:0] in_word1;
    logic [31:0] in_word0;
  } in_t;

  typedef struct packed {
    logic [31:0] out_word3;
    logic [31:0] out_word2;
    logic [31:0] out_word1;
    logic [31:0] out_word0;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_KLOAD, ST_KEXP, ST_PRE, ST_ROUND, ST_FIN, ST_HOLD
  } st_t;

  localparam logic [3:0] SBOX_FWD [8][16] = '{
    '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
      4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
    '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
      4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
    '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
      4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
    '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
      4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
    '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
      4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
    '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
      4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
    '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
      4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
    '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
      4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
  };

  localparam logic [3:0] SBOX_INV [8][16] = '{
    '{4'd13, 4'd3, 4'd11, 4'd0, 4'd10, 4'd6, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd15, 4'd9, 4'd8, 4'd2},
    '{4'd5, 4'd8, 4'd2, 4'd14, 4'd15, 4'd6, 4'd12, 4'd3,
      4'd11, 4'd4, 4'd7, 4'd9, 4'd1, 4'd13, 4'd10, 4'd0},
    '{4'd12, 4'd9, 4'd15, 4'd4, 4'd11, 4'd14, 4'd1, 4'd2,
      4'd0, 4'd3, 4'd6, 4'd13, 4'd5, 4'd8, 4'd10, 4'd7},
    '{4'd0, 4'd9, 4'd10, 4'd7, 4'd11, 4'd14, 4'd6, 4'd13,
      4'd3, 4'd5, 4'd12, 4'd2, 4'd4, 4'd8, 4'd15, 4'd1},
    '{4'd5, 4'd0, 4'd8, 4'd3, 4'd10, 4'd9, 4'd7, 4'd14,
      4'd2, 4'd12, 4'd11, 4'd6, 4'd4, 4'd15, 4'd13, 4'd1},
    '{4'd8, 4'd15, 4'd2, 4'd9, 4'd4, 4'd1, 4'd13, 4'd14,
      4'd11, 4'd6, 4'd5, 4'd3, 4'd7, 4'd12, 4'd10, 4'd0},
    '{4'd15, 4'd10, 4'd1, 4'd13, 4'd5, 4'd3, 4'd6, 4'd0,
      4'd4, 4'd9, 4'd14, 4'd7, 4'd2, 4'd12, 4'd8, 4'd11},
    '{4'd3, 4'd0, 4'd6, 4'd13, 4'd9, 4'd14, 4'd15, 4'd8,
      4'd5, 4'd12, 4'd11, 4'd7, 4'd10, 4'd1, 4'd4, 4'd2}
  };

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction

  // One S-box on all 32 bit columns; word k carries bit k of each nibble.
  function automatic blk_t sbox_layer(input blk_t w, input logic [2:0] box,
                                      input logic inv);
    blk_t       r;
    logic [3:0] n;
    logic [3:0] v;
    for (int j = 0; j < 32; j++) begin
      n = {w[3][j], w[2][j], w[1][j], w[0][j]};
      v = inv ? SBOX_INV[box][n] : SBOX_FWD[box][n];
      for (int k = 0; k < 4; k++) begin
        r[k][j] = v[k];
      end
    end
    return r;
  endfunction

  function automatic blk_t lin_fwd(input blk_t xi);
    blk_t x;
    x = xi;
    x[0] = rol32(x[0], 13);
    x[2] = rol32(x[2], 3);
    x[1] = x[1] ^ x[0] ^ x[2];
    x[3] = x[3] ^ x[2] ^ (x[0] << 3);
    x[1] = rol32(x[1], 1);
    x[3] = rol32(x[3], 7);
    x[0] = x[0] ^ x[1] ^ x[3];
    x[2] = x[2] ^ x[3] ^ (x[1] << 7);
    x[0] = rol32(x[0], 5);
    x[2] = rol32(x[2], 22);
    return x;
  endfunction

  function automatic blk_t lin_inv(input blk_t xi);
    blk_t x;
    x = xi;
    x[2] = rol32(x[2], 10);
    x[0] = rol32(x[0], 27);
    x[2] = x[2] ^ x[3] ^ (x[1] << 7);
    x[0] = x[0] ^ x[1] ^ x[3];
    x[3] = rol32(x[3], 25);
    x[1] = rol32(x[1], 31);
    x[3] = x[3] ^ x[2] ^ (x[0] << 3);
    x[1] = x[1] ^ x[0] ^ x[2];
    x[2] = rol32(x[2], 29);
    x[0] = rol32(x[0], 19);
    return x;
  endfunction

endpackage
`default_nettype wire

### rtl/core/serpent_block_cipher.sv
// Serpent block cipher top level: APB key registers, 33 x 128-bit subkey RAM, one round
// per cycle with one subkey row read. Uses spb_pkg and spb_ram.
// One block at a time: a new block is taken only in idle; a result waiting for the output register holds the core.
// Key expansion: in_ready low while it runs after reset or a key write (idle, load, 132 words).
// Reset (rst_n, synchronous): 256-bit all-zero key, subkeys not yet expanded.
`default_nettype none
module serpent_block_cipher (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire spb_pkg::in_t                 in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output spb_pkg::out_t                     out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [spb_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [spb_pkg::CFG_DW-1:0]   pwdata,
  output logic      [spb_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready
);
  import spb_pkg::*;

  // configuration registers
  logic [1:0]  klen_r;
  logic [63:0] key_r [4];
  logic [2:0]  reg_idx;
  logic        cfg_wr;
  logic        cfg_hit;

  // control
  st_t               state_r, state_nxt;
  logic              keys_ok_r, keys_ok_nxt;
  logic              dec_r, dec_nxt;
  logic [ROW_AW-1:0] rnd_r, rnd_nxt;
  logic [WORD_IW-1:0] idx_r, idx_nxt;
  logic              in_xfer;
  logic              out_free;
  logic              out_load;

  // datapath
  blk_t        x_r, x_nxt;
  blk_t        kw;
  blk_t        y;
  out_t        out_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] win_r [8];
  logic [31:0] grp_r [3];
  logic [31:0] t_word;
  logic [31:0] key_word [8];
  logic [3:0]  nwords;

  // subkey RAM
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  logic [127:0]      ram_wdata, ram_rdata;

  spb_ram #(.WIDTH(128), .DEPTH(KEY_ROWS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- APB ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && (reg_idx inside {REG_KLEN, REG_KEY0, REG_KEY1,
                                               REG_KEY2, REG_KEY3});

  always_comb begin
    case (reg_idx)
      REG_KLEN: prdata = {62'd0, klen_r};
      REG_KEY0: prdata = key_r[0];
      REG_KEY1: prdata = key_r[1];
      REG_KEY2: prdata = key_r[2];
      REG_KEY3: prdata = key_r[3];
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KLEN_256;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KLEN: klen_r <= (pwdata[1:0] == KLEN_RSV) ? KLEN_256 : pwdata[1:0];
        REG_KEY0: key_r[0] <= pwdata;
        REG_KEY1: key_r[1] <= pwdata;
        REG_KEY2: key_r[2] <= pwdata;
        REG_KEY3: key_r[3] <= pwdata;
        default:  ;
      endcase
    end
  end

  // ---------------- next state ----------------
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!keys_ok_r) begin
          state_nxt = ST_KLOAD;
        end else if (in_xfer) begin
          state_nxt = (in_data.opcode == OP_DEC) ? ST_PRE : ST_ROUND;
        end
      end
      ST_KLOAD: state_nxt = ST_KEXP;
      ST_KEXP: begin
        if (idx_r == WORD_IW'(KEY_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PRE: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (dec_r == OP_ENC) begin
          if (rnd_r == ROW_AW'(ROUND_COUNT - 1)) begin
            state_nxt = ST_FIN;
          end
        end else if (rnd_r == '0) begin
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_FIN:  state_nxt = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: state_nxt = out_free ? ST_IDLE : ST_HOLD;
      default: state_nxt = ST_IDLE;
    endcase
    // a key write restarts a running expansion
    if (cfg_hit && (state_r == ST_KLOAD || state_r == ST_KEXP)) begin
      state_nxt = ST_KLOAD;
    end
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = keys_ok_r;
        ram_raddr = (in_data.opcode == OP_DEC) ? ROW_AW'(ROUND_COUNT) : '0;
      end
      ST_KEXP:  ram_we = (idx_r[1:0] == 2'd3);
      ST_PRE:   ram_raddr = ROW_AW'(ROUND_COUNT - 1);
      ST_ROUND: begin
        ram_raddr = (dec_r == OP_DEC) ? rnd_r - 1'b1 : rnd_r + 1'b1;
        out_load  = (dec_r == OP_DEC) && (rnd_r == '0) && out_free;
      end
      ST_FIN:   out_load = out_free;
      ST_HOLD:  out_load = out_free;
      default:  ;
    endcase
  end

  // ---------------- round datapath ----------------
  assign kw = ram_rdata;

  always_comb begin
    case (state_r)
      ST_ROUND: begin
        if (dec_r == OP_ENC) begin
          y = sbox_layer(x_r ^ kw, rnd_r[2:0], 1'b0);
          if (rnd_r != ROW_AW'(ROUND_COUNT - 1)) begin
            y = lin_fwd(y);
          end
        end else begin
          y = (rnd_r == ROW_AW'(ROUND_COUNT - 1)) ? x_r : lin_inv(x_r);
          y = sbox_layer(y, rnd_r[2:0], 1'b1) ^ kw;
        end
      end
      ST_PRE, ST_FIN: y = x_r ^ kw;
      default:        y = x_r;
    endcase
  end

  // ---------------- key expansion ----------------
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_word[i] = key_r[i / 2][(i % 2) * 32 +: 32];
    end
    case (klen_r)
      KLEN_128: nwords = 4'd4;
      KLEN_192: nwords = 4'd6;
      default:  nwords = 4'd8;
    endcase
  end

  assign t_word = rol32(win_r[0] ^ win_r[3] ^ win_r[5] ^ win_r[7] ^ GOLDEN
                        ^ {{(32 - WORD_IW){1'b0}}, idx_r}, 11);

  // group g goes through S-box (3 - g) mod 8
  assign ram_waddr = idx_r[WORD_IW-1:2];
  assign ram_wdata = sbox_layer({t_word, grp_r[2], grp_r[1], grp_r[0]},
                                3'd3 - idx_r[4:2], 1'b0);

  always_ff @(posedge clk) begin
    if (state_r == ST_KLOAD) begin
      for (int i = 0; i < 8; i++) begin
        if (4'(i) < nwords) begin
          win_r[i] <= key_word[i];
        end else if (4'(i) == nwords) begin
          win_r[i] <= 32'd1;
        end else begin
          win_r[i] <= 32'd0;
        end
      end
    end else if (state_r == ST_KEXP) begin
      for (int i = 0; i < 7; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[7] <= t_word;
      if (idx_r[1:0] != 2'd3) begin
        grp_r[idx_r[1:0]] <= t_word;
      end
    end
  end

  // ---------------- register updates ----------------
  always_comb begin
    keys_ok_nxt   = keys_ok_r;
    dec_nxt       = dec_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    x_nxt         = y;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          dec_nxt = in_data.opcode;
          rnd_nxt = (in_data.opcode == OP_DEC) ? ROW_AW'(ROUND_COUNT - 1) : '0;
          x_nxt   = {in_data.in_word3, in_data.in_word2,
                     in_data.in_word1, in_data.in_word0};
        end
      end
      ST_KLOAD: idx_nxt = '0;
      ST_KEXP: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == WORD_IW'(KEY_WORDS - 1)) begin
          keys_ok_nxt = 1'b1;
        end
      end
      ST_ROUND: rnd_nxt = (dec_r == OP_DEC) ? rnd_r - 1'b1 : rnd_r + 1'b1;
      default:  ;
    endcase
    if (cfg_hit) begin
      keys_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      keys_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rnd_r       <= '0;
      idx_r       <= '0;
      dec_r       <= OP_ENC;
    end else begin
      state_r     <= state_nxt;
      keys_ok_r   <= keys_ok_nxt;
      out_valid_r <= out_valid_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      dec_r       <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (out_load) begin
      out_r <= (state_r == ST_HOLD) ? out_t'(x_r) : out_t'(y);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

### rtl/core/spb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module spb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/spb_checker.sv
// Port-level checks for serpent_block_cipher, bound to the top level.
// Uses spb_pkg for the payload type and the register indices.
`default_nettype none
module spb_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire spb_pkg::out_t              out_data,
  input wire logic                       psel,
  input wire logic                       penable,
  input wire logic                       pwrite,
  input wire logic [spb_pkg::CFG_AW-1:0] paddr
);
  import spb_pkg::*;

  // one block at a time: no second transfer right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a result cannot appear the cycle after a block is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");

  // key write forces re-expansion before the next block
  a_key_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr[5:3] <= REG_KEY3) |=> !in_ready)
    else $error("input ready right after key write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");
endmodule

bind serpent_block_cipher spb_checker u_spb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr)
);
`default_nettype wire

### sim/serpent_block_cipher_check.sv
// Checker for the Serpent block cipher: follows APB key writes, expands the
// key on its own, predicts every block and compares results. Uses spb_pkg.
module serpent_block_cipher_check (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire spb_pkg::in_t               in_data,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire spb_pkg::out_t              out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic                       pready,
  input  wire logic [spb_pkg::CFG_AW-1:0] paddr,
  input  wire logic [spb_pkg::CFG_DW-1:0] pwdata,
  output int                              errors,
  output int                              pending
);
  import spb_pkg::*;

  typedef logic [3:0][31:0] quad_t;

  localparam logic [3:0] FWD_BOX [8][16] = '{
    '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
      4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
    '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
      4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
    '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
      4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
    '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
      4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
    '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
      4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
    '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
      4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
    '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
      4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
    '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
      4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
  };

  logic [1:0]  key_len;
  logic [63:0] key_reg [4];
  logic [31:0] round_keys [132];
  bit          keys_valid;
  out_t        expected_blocks [$];

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic quad_t sbox(quad_t w, int box, bit inv);
    logic [3:0] tab [16];
    logic [3:0] n;
    quad_t r;
    for (int k = 0; k < 16; k++) begin
      if (inv) tab[FWD_BOX[box][k]] = k[3:0];
      else tab[k] = FWD_BOX[box][k];
    end
    for (int j = 0; j < 32; j++) begin
      n = {w[3][j], w[2][j], w[1][j], w[0][j]};
      for (int k = 0; k < 4; k++) r[k][j] = tab[n][k];
    end
    return r;
  endfunction

  function automatic quad_t mix_fwd(quad_t x);
    x[0] = rotl(x[0], 13);
    x[2] = rotl(x[2], 3);
    x[1] ^= x[0] ^ x[2];
    x[3] ^= x[2] ^ (x[0] << 3);
    x[1] = rotl(x[1], 1);
    x[3] = rotl(x[3], 7);
    x[0] ^= x[1] ^ x[3];
    x[2] ^= x[3] ^ (x[1] << 7);
    x[0] = rotl(x[0], 5);
    x[2] = rotl(x[2], 22);
    return x;
  endfunction

  function automatic quad_t mix_inv(quad_t x);
    x[2] = rotl(x[2], 32 - 22);
    x[0] = rotl(x[0], 32 - 5);
    x[2] ^= x[3] ^ (x[1] << 7);
    x[0] ^= x[1] ^ x[3];
    x[3] = rotl(x[3], 32 - 7);
    x[1] = rotl(x[1], 32 - 1);
    x[3] ^= x[2] ^ (x[0] << 3);
    x[1] ^= x[0] ^ x[2];
    x[2] = rotl(x[2], 32 - 3);
    x[0] = rotl(x[0], 32 - 13);
    return x;
  endfunction

  task automatic expand_key();
    logic [31:0] win [8];
    logic [31:0] t;
    quad_t q;
    int nwords;
    nwords = (key_len == KLEN_128) ? 4 : (key_len == KLEN_192) ? 6 : 8;
    for (int i = 0; i < 8; i++) begin
      if (i < nwords) win[i] = key_reg[i / 2][32 * (i % 2) +: 32];
      else win[i] = (i == nwords) ? 32'd1 : 32'd0;
    end
    for (int i = 0; i < 132; i++) begin
      t = win[i % 8] ^ win[(i + 3) % 8] ^ win[(i + 5) % 8] ^ win[(i + 7) % 8]
          ^ GOLDEN ^ i;
      t = rotl(t, 11);
      win[i % 8] = t;
      round_keys[i] = t;
    end
    for (int g = 0; g < 33; g++) begin
      for (int k = 0; k < 4; k++) q[k] = round_keys[4 * g + k];
      q = sbox(q, (67 - g) % 8, 1'b0);
      for (int k = 0; k < 4; k++) round_keys[4 * g + k] = q[k];
    end
    keys_valid = 1;
  endtask

  function automatic quad_t add_key(quad_t x, int rnd);
    for (int k = 0; k < 4; k++) x[k] ^= round_keys[4 * rnd + k];
    return x;
  endfunction

  task automatic predict_block(in_t item);
    quad_t x;
    out_t o;
    if (!keys_valid) expand_key();
    x = {item.in_word3, item.in_word2, item.in_word1, item.in_word0};
    if (item.opcode == OP_ENC) begin
      for (int r = 0; r < 32; r++) begin
        x = sbox(add_key(x, r), r % 8, 1'b0);
        x = (r < 31) ? mix_fwd(x) : add_key(x, 32);
      end
    end else begin
      for (int r = 31; r >= 0; r--) begin
        x = (r == 31) ? add_key(x, 32) : mix_inv(x);
        x = add_key(sbox(x, r % 8, 1'b1), r);
      end
    end
    o = {x[3], x[2], x[1], x[0]};
    expected_blocks = {expected_blocks, o};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_len    = KLEN_256;
      key_reg    = '{default: '0};
      keys_valid = 0;
      errors     <= 0;
      expected_blocks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_KLEN: begin
            key_len    = (pwdata[1:0] == KLEN_RSV) ? KLEN_256 : pwdata[1:0];
            keys_valid = 0;
          end
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
            key_reg[2'(paddr[5:3] - REG_KEY0)] = pwdata;
            keys_valid = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_block(in_data);
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", out_data);
          errors <= errors + 1;
        end else begin
          out_t e;
          e = expected_blocks.pop_front();
          if (e !== out_data) begin
            if (errors < 10) $display("mismatch: expected %h got %h", e, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
    pending = expected_blocks.size();
  end
endmodule

### sim/serpent_block_cipher_test.sv
// Testbench top for serpent_block_cipher: clock, reset, APB key writes,
// block stimulus and verdict. Uses spb_pkg and serpent_block_cipher_check.
module serpent_block_cipher_test;
  import spb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [2:0] REG_STRAY = 3'd5;  // past the register list

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;
  int errors, pending, cycles;
  bit no_gaps;  // stretches of back-to-back transfers

  serpent_block_cipher dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  serpent_block_cipher_check check (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watchdog: no correct run comes near this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: each result is held off for a random stall, sometimes none.
  initial begin
    int stall;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 0;
        @(posedge clk iff out_valid);
        repeat (stall - 1) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk iff out_valid);
    end
  end

  // APB write: setup cycle, then access cycle; reg lands on the access edge.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    psel    <= 1;
    pwrite  <= 1;
    penable <= 0;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    @(posedge clk);
  endtask

  // Only reconfigure once every outstanding block has come back.
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One block transfer; valid stays up across back-to-back items.
  task automatic send_block(logic op, logic [31:0] w3, logic [31:0] w2,
                            logic [31:0] w1, logic [31:0] w0);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= '{opcode: op, in_word3: w3, in_word2: w2, in_word1: w1, in_word0: w0};
    @(posedge clk iff in_ready);
  endtask

  task automatic send_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 40) == 0) no_gaps = ~no_gaps;
      send_block($urandom_range(0, 1), pick_word(), pick_word(), pick_word(),
                 pick_word());
    end
    in_valid <= 0;
  endtask

  initial begin
    rst_n    = 0;
    in_valid = 0;
    in_data  = '0;
    psel     = 0;
    penable  = 0;
    pwrite   = 0;
    paddr    = '0;
    pwdata   = '0;
    cycles   = 0;
    no_gaps  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Blocks before any key write: reset key (all-zero 256-bit).
    send_block(OP_ENC, '0, '0, '0, '0);
    send_block(OP_DEC, '0, '0, '0, '0);
    send_block(OP_ENC, '1, '1, '1, '1);
    send_block(OP_DEC, '1, '1, '1, '1);
    in_valid <= 0;
    drain();

    // Directed: every key length, reserved code, all-ones key, stray address.
    write_reg(REG_KEY0, '1);
    write_reg(REG_KEY1, '1);
    write_reg(REG_KEY2, '1);
    write_reg(REG_KEY3, '1);
    write_reg(REG_STRAY, 64'h1234_5678_9ABC_DEF0);
    for (int code = 0; code < 4; code++) begin
      write_reg(REG_KLEN, code);
      send_block(OP_ENC, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_block(OP_DEC, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_block(OP_ENC, '1, '0, '1, '0);
      send_block(OP_DEC, '0, '1, '0, '1);
      in_valid <= 0;
      drain();
    end

    // Random key phases; block back-to-back stretches included.
    for (int phase = 0; phase < 12; phase++) begin
      write_reg(REG_KLEN, $urandom_range(0, 3));
      for (int r = 1; r <= 4; r++) begin
        if ($urandom_range(0, 3) != 0) write_reg(r[2:0], pick_key());
      end
      send_random(150);
      drain();
    end

    // Test complete: final verdict.
    if (errors == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
